// File: rtl/core/color_wheel_pixel_converter_top_macros.svh
// Assertion helpers shared by the colour wheel pipeline.
`ifndef COLOR_WHEEL_PIXEL_CONVERTER_TOP_MACROS_SVH
`define COLOR_WHEEL_PIXEL_CONVERTER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define CWPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cwpc: same-cycle check failed");

// Next-cycle implication.
`define CWPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cwpc: next-cycle check failed");

`endif

// File: rtl/core/cwpc_pkg.sv
package cwpc_pkg;

  localparam int FRAC_BITS_DEF = 12;
  localparam int DIST_BITS_DEF = 10;

  localparam int HUE_W      = 15;
  localparam int DIST_W     = 10;
  localparam int MODE_W     = 2;
  localparam int RADIUS_W   = 10;
  localparam int LEVEL_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int CHAN_W     = 8;
  localparam int CHAN_MAX   = 255;

  // 255 * angle >> FRAC_BITS never exceeds 1530, which fits in 11 bits.
  localparam int GPRE_W     = 11;
  // floor(n / 6) == (n * 683) >> 12 for every n up to 1530.
  localparam int DIV6_MUL   = 683;
  localparam int DIV6_MUL_W = 10;
  localparam int DIV6_SHIFT = 12;

  typedef enum logic [MODE_W-1:0] {
    MODE_RGB = 2'd0,
    MODE_CMY = 2'd1,
    MODE_HSV = 2'd2,
    MODE_HSL = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WHEEL_MODE   = 2'd0,
    REG_WHEEL_RADIUS = 2'd1,
    REG_LEVEL        = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  localparam mode_t                MODE_RST   = MODE_HSV;
  localparam logic [RADIUS_W-1:0]  RADIUS_RST = 10'd256;
  localparam logic [LEVEL_W-1:0]   LEVEL_RST  = 13'd4096;

  typedef struct packed {
    mode_t   mode;
    sector_t sector;
  } ctl_t;

  typedef struct packed {
    mode_t                wheel_mode;
    logic [RADIUS_W-1:0]  wheel_radius;
    logic [LEVEL_W-1:0]   level;
  } cfg_t;

  typedef struct packed {
    logic [HUE_W-1:0]  hue_angle;
    logic [DIST_W-1:0] radial_distance;
  } in_beat_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } out_pix_t;

endpackage

// File: rtl/core/cwpc_prep.sv
module cwpc_prep #(
  parameter int FRAC_BITS = cwpc_pkg::FRAC_BITS_DEF,
  parameter int DIST_BITS = cwpc_pkg::DIST_BITS_DEF,
  localparam int DW = (DIST_BITS < cwpc_pkg::DIST_W) ? DIST_BITS : cwpc_pkg::DIST_W,
  localparam int LW = FRAC_BITS + 1,
  localparam int NW = DW + FRAC_BITS + 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cwpc_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cwpc_pkg::in_beat_t            in_data,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic [NW-1:0]                 dn_num,
  output logic [DW-1:0]                 dn_rad,
  output cwpc_pkg::ctl_t                dn_ctl,
  output logic [LW-1:0]                 dn_lv,
  output logic [LW-1:0]                 dn_k,
  output logic [LW-1:0]                 dn_f,
  output logic [cwpc_pkg::GPRE_W-1:0]   dn_gpre,
  output logic [cwpc_pkg::CHAN_W-1:0]   dn_blue
);

  localparam int AW   = FRAC_BITS + 3;
  localparam int ONE  = 1 << FRAC_BITS;
  localparam int TURN = 6 * ONE;
  localparam int HXW  = (cwpc_pkg::HUE_W > AW) ? cwpc_pkg::HUE_W : AW;
  localparam int LXW  = (cwpc_pkg::LEVEL_W > LW) ? cwpc_pkg::LEVEL_W : LW;
  localparam logic [AW-1:0] TURN_A = AW'(TURN);
  localparam logic [LW-1:0] ONE_L  = LW'(ONE);

  logic en1;
  logic en2;

  // Stage one: clamp the angle, level, radius and distance.
  logic [HXW-1:0] hue_x;
  logic [LXW-1:0] lvl_x;
  logic [AW-1:0]  a_nxt;
  logic [LW-1:0]  lv_nxt;
  logic [DW-1:0]  rad_raw;
  logic [DW-1:0]  rad_nxt;
  logic [DW-1:0]  d_raw;
  logic [DW-1:0]  d_nxt;

  logic              s1_valid_r;
  cwpc_pkg::mode_t   s1_mode_r;
  logic [AW-1:0]     s1_a_r;
  logic [LW-1:0]     s1_lv_r;
  logic [DW-1:0]     s1_rad_r;
  logic [DW-1:0]     s1_d_r;

  assign hue_x   = HXW'(in_data.hue_angle);
  assign a_nxt   = (hue_x > HXW'(TURN)) ? TURN_A : hue_x[AW-1:0];
  assign lvl_x   = LXW'(cfg.level);
  assign lv_nxt  = (lvl_x > LXW'(ONE)) ? ONE_L : lvl_x[LW-1:0];
  assign rad_raw = cfg.wheel_radius[DW-1:0];
  assign rad_nxt = (rad_raw == '0) ? DW'(1) : rad_raw;
  assign d_raw   = in_data.radial_distance[DW-1:0];
  assign d_nxt   = (d_raw > rad_nxt) ? rad_nxt : d_raw;

  // Stage two: divider numerator, chroma factor, hue ramp, sector, and the linear green and blue terms.
  logic [DW-1:0]              lin_src;
  logic [NW-1:0]              num_lin;
  logic [NW-1:0]              num_sat;
  logic [NW-1:0]              num_nxt;
  logic [LW-1:0]              a_mod;
  logic [LW:0]                f_up;
  logic [LW-1:0]              f_nxt;
  logic [LW:0]                lv2;
  logic [LW:0]                k_dn;
  logic [LW-1:0]              k_hsl;
  logic [LW-1:0]              k_nxt;
  cwpc_pkg::sector_t          sector_nxt;
  logic [AW-1:0]              g_src;
  logic [AW+7:0]              g_prod;
  logic [LW-1:0]              b_src;
  logic [LW+7:0]              b_prod;
  logic                       is_cmy;
  logic                       is_lin;

  logic                       s2_valid_r;
  logic [NW-1:0]              s2_num_r;
  logic [DW-1:0]              s2_rad_r;
  cwpc_pkg::ctl_t             s2_ctl_r;
  logic [LW-1:0]              s2_lv_r;
  logic [LW-1:0]              s2_k_r;
  logic [LW-1:0]              s2_f_r;
  logic [cwpc_pkg::GPRE_W-1:0] s2_gpre_r;
  logic [cwpc_pkg::CHAN_W-1:0] s2_blue_r;

  assign is_cmy  = (s1_mode_r == cwpc_pkg::MODE_CMY);
  assign is_lin  = (s1_mode_r == cwpc_pkg::MODE_RGB) || is_cmy;

  assign lin_src = is_cmy ? (s1_rad_r - s1_d_r) : s1_d_r;
  assign num_lin = (NW'(lin_src) << 8) - NW'(lin_src);
  assign num_sat = NW'(s1_d_r) << FRAC_BITS;
  assign num_nxt = is_lin ? num_lin : num_sat;

  // Triangle over each third of a turn: one on odd sector edges, zero on even ones.
  assign a_mod = s1_a_r[LW-1:0];
  assign f_up  = (LW+1)'(2 * ONE) - (LW+1)'(a_mod);
  assign f_nxt = (a_mod >= ONE_L) ? f_up[LW-1:0] : a_mod;

  assign lv2   = {s1_lv_r, 1'b0};
  assign k_dn  = (LW+1)'(2 * ONE) - lv2;
  assign k_hsl = (lv2 >= (LW+1)'(ONE)) ? k_dn[LW-1:0] : lv2[LW-1:0];
  assign k_nxt = (s1_mode_r == cwpc_pkg::MODE_HSL) ? k_hsl : s1_lv_r;

  // An angle sitting exactly on a boundary belongs to the lower sector.
  always_comb begin
    if (s1_a_r <= AW'(ONE)) begin
      sector_nxt = cwpc_pkg::SEC_RED_YEL;
    end else if (s1_a_r <= AW'(2 * ONE)) begin
      sector_nxt = cwpc_pkg::SEC_YEL_GRN;
    end else if (s1_a_r <= AW'(3 * ONE)) begin
      sector_nxt = cwpc_pkg::SEC_GRN_CYN;
    end else if (s1_a_r <= AW'(4 * ONE)) begin
      sector_nxt = cwpc_pkg::SEC_CYN_BLU;
    end else if (s1_a_r <= AW'(5 * ONE)) begin
      sector_nxt = cwpc_pkg::SEC_BLU_MAG;
    end else begin
      sector_nxt = cwpc_pkg::SEC_MAG_RED;
    end
  end

  assign g_src  = is_cmy ? (TURN_A - s1_a_r) : s1_a_r;
  assign g_prod = ((AW+8)'(g_src) << 8) - (AW+8)'(g_src);
  assign b_src  = is_cmy ? (ONE_L - s1_lv_r) : s1_lv_r;
  assign b_prod = ((LW+8)'(b_src) << 8) - (LW+8)'(b_src);

  assign en2      = !s2_valid_r || dn_ready;
  assign en1      = !s1_valid_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid_r <= in_valid;
      end
      if (en2) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_mode_r <= cfg.wheel_mode;
      s1_a_r    <= a_nxt;
      s1_lv_r   <= lv_nxt;
      s1_rad_r  <= rad_nxt;
      s1_d_r    <= d_nxt;
    end
    if (en2) begin
      s2_num_r         <= num_nxt;
      s2_rad_r         <= s1_rad_r;
      s2_ctl_r.mode    <= s1_mode_r;
      s2_ctl_r.sector  <= sector_nxt;
      s2_lv_r          <= s1_lv_r;
      s2_k_r           <= k_nxt;
      s2_f_r           <= f_nxt;
      s2_gpre_r        <= g_prod[AW+7:FRAC_BITS];
      s2_blue_r        <= b_prod[FRAC_BITS +: cwpc_pkg::CHAN_W];
    end
  end

  assign dn_valid = s2_valid_r;
  assign dn_num   = s2_num_r;
  assign dn_rad   = s2_rad_r;
  assign dn_ctl   = s2_ctl_r;
  assign dn_lv    = s2_lv_r;
  assign dn_k     = s2_k_r;
  assign dn_f     = s2_f_r;
  assign dn_gpre  = s2_gpre_r;
  assign dn_blue  = s2_blue_r;

endmodule

// File: rtl/core/cwpc_div.sv
`include "color_wheel_pixel_converter_top_macros.svh"

module cwpc_div #(
  parameter int FRAC_BITS = cwpc_pkg::FRAC_BITS_DEF,
  parameter int DIST_BITS = cwpc_pkg::DIST_BITS_DEF,
  parameter int TAG_W     = 1,
  localparam int DW = (DIST_BITS < cwpc_pkg::DIST_W) ? DIST_BITS : cwpc_pkg::DIST_W,
  localparam int QB = FRAC_BITS + 1,
  localparam int NW = DW + QB
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [NW-1:0]    up_num,
  input  logic [DW-1:0]    up_rad,
  input  logic [TAG_W-1:0] up_tag,
  output logic             dn_valid,
  input  logic             dn_ready,
  output logic [QB-1:0]    dn_quo,
  output logic [TAG_W-1:0] dn_tag
);

  // Restoring division, one quotient bit per stage, most significant first.
  // The numerator is always below radius << QB, so QB bits suffice.
  logic             valid_r [QB];
  logic [NW-1:0]    rem_r   [QB];
  logic [DW-1:0]    rad_r   [QB];
  logic [QB-1:0]    quo_r   [QB];
  logic [TAG_W-1:0] tag_r   [QB];
  logic             en      [QB];

  genvar j;
  for (j = 0; j < QB; j++) begin : g_step
    localparam int BIT = QB - 1 - j;

    logic             v_in;
    logic [NW-1:0]    rem_in;
    logic [DW-1:0]    rad_in;
    logic [QB-1:0]    quo_in;
    logic [TAG_W-1:0] tag_in;
    logic             dn_en;
    logic [NW-1:0]    trial;
    logic             take;
    logic [NW-1:0]    rem_nxt;
    logic [QB-1:0]    quo_nxt;

    if (j == 0) begin : g_head
      assign v_in   = up_valid;
      assign rem_in = up_num;
      assign rad_in = up_rad;
      assign quo_in = '0;
      assign tag_in = up_tag;
    end else begin : g_body
      assign v_in   = valid_r[j-1];
      assign rem_in = rem_r[j-1];
      assign rad_in = rad_r[j-1];
      assign quo_in = quo_r[j-1];
      assign tag_in = tag_r[j-1];
    end

    if (j == QB - 1) begin : g_last
      assign dn_en = dn_ready;
    end else begin : g_mid
      assign dn_en = en[j+1];
    end

    assign en[j]   = !valid_r[j] || dn_en;
    assign trial   = NW'(rad_in) << BIT;
    assign take    = (rem_in >= trial);
    assign rem_nxt = take ? (rem_in - trial) : rem_in;
    assign quo_nxt = quo_in | (QB'(take) << BIT);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[j] <= 1'b0;
      end else if (en[j]) begin
        valid_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_r[j] <= rem_nxt;
        rad_r[j] <= rad_in;
        quo_r[j] <= quo_nxt;
        tag_r[j] <= tag_in;
      end
    end
  end

  assign up_ready = en[0];
  assign dn_valid = valid_r[QB-1];
  assign dn_quo   = quo_r[QB-1];
  assign dn_tag   = tag_r[QB-1];

  `CWPC_ASSERT_IMP(a_rem_below_rad, clk, rst_n, valid_r[QB-1], rem_r[QB-1] < NW'(rad_r[QB-1]))
  `CWPC_ASSERT_IMP(a_quo_in_range, clk, rst_n, valid_r[QB-1], quo_r[QB-1] <= QB'(1 << FRAC_BITS))

endmodule

// File: rtl/core/cwpc_mix.sv
`include "color_wheel_pixel_converter_top_macros.svh"

module cwpc_mix #(
  parameter int FRAC_BITS = cwpc_pkg::FRAC_BITS_DEF,
  localparam int LW = FRAC_BITS + 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [LW-1:0]                 up_quo,
  input  cwpc_pkg::ctl_t                up_ctl,
  input  logic [LW-1:0]                 up_lv,
  input  logic [LW-1:0]                 up_k,
  input  logic [LW-1:0]                 up_f,
  input  logic [cwpc_pkg::GPRE_W-1:0]   up_gpre,
  input  logic [cwpc_pkg::CHAN_W-1:0]   up_blue,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output cwpc_pkg::out_pix_t            dn_pix
);

  localparam int TW = FRAC_BITS + 3;
  localparam int PW = TW + 8;
  localparam int GW = cwpc_pkg::GPRE_W + cwpc_pkg::DIV6_MUL_W;
  localparam int CW = cwpc_pkg::CHAN_W;

  logic en1;
  logic en2;
  logic en3;
  logic en4;

  // Stage one: chroma = k * s, and the linear green ramp divided by six.
  logic [2*LW-1:0] c_prod;
  logic [GW-1:0]   g_prod;

  logic            m1_valid_r;
  cwpc_pkg::ctl_t  m1_ctl_r;
  logic [LW-1:0]   m1_lv_r;
  logic [LW-1:0]   m1_f_r;
  logic [LW-1:0]   m1_c_r;
  logic [CW-1:0]   m1_red_r;
  logic [CW-1:0]   m1_green_r;
  logic [CW-1:0]   m1_blue_r;

  assign c_prod = (2*LW)'(up_k) * (2*LW)'(up_quo);
  assign g_prod = GW'(up_gpre) * GW'(cwpc_pkg::DIV6_MUL);

  // Stage two: secondary component x = c * f.
  logic [2*LW-1:0] x_prod;

  logic            m2_valid_r;
  cwpc_pkg::ctl_t  m2_ctl_r;
  logic [LW-1:0]   m2_lv_r;
  logic [LW-1:0]   m2_c_r;
  logic [LW-1:0]   m2_x_r;
  logic [CW-1:0]   m2_red_r;
  logic [CW-1:0]   m2_green_r;
  logic [CW-1:0]   m2_blue_r;

  assign x_prod = (2*LW)'(m1_c_r) * (2*LW)'(m1_f_r);

  // Stage three: place c and x by sector and add the level offset.
  logic [LW-1:0]   v     [3];
  logic [TW-1:0]   base  [3];
  logic [TW-1:0]   t_nxt [3];

  logic            m3_valid_r;
  cwpc_pkg::mode_t m3_mode_r;
  logic [TW-1:0]   m3_t_r [3];
  logic [CW-1:0]   m3_red_r;
  logic [CW-1:0]   m3_green_r;
  logic [CW-1:0]   m3_blue_r;

  always_comb begin
    case (m2_ctl_r.sector)
      cwpc_pkg::SEC_RED_YEL: begin
        v[0] = m2_c_r; v[1] = m2_x_r; v[2] = '0;
      end
      cwpc_pkg::SEC_YEL_GRN: begin
        v[0] = m2_x_r; v[1] = m2_c_r; v[2] = '0;
      end
      cwpc_pkg::SEC_GRN_CYN: begin
        v[0] = '0; v[1] = m2_c_r; v[2] = m2_x_r;
      end
      cwpc_pkg::SEC_CYN_BLU: begin
        v[0] = '0; v[1] = m2_x_r; v[2] = m2_c_r;
      end
      cwpc_pkg::SEC_BLU_MAG: begin
        v[0] = m2_x_r; v[1] = '0; v[2] = m2_c_r;
      end
      cwpc_pkg::SEC_MAG_RED: begin
        v[0] = m2_c_r; v[1] = '0; v[2] = m2_x_r;
      end
      default: begin
        v[0] = '0; v[1] = '0; v[2] = '0;
      end
    endcase
  end

  // HSL keeps m = L - c/2 exact by working at twice the scale.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (m2_ctl_r.mode == cwpc_pkg::MODE_HSL) begin
        base[i] = (TW'(v[i]) << 1) + (TW'(m2_lv_r) << 1);
      end else begin
        base[i] = TW'(v[i]) + TW'(m2_lv_r);
      end
      t_nxt[i] = base[i] - TW'(m2_c_r);
    end
  end

  // Stage four: scale to 8 bits and pick the channel set for the mode.
  logic [PW-1:0]   p_full [3];
  logic [PW-1:0]   p_shr  [3];
  logic [CW-1:0]   ch     [3];
  cwpc_pkg::out_pix_t pix_nxt;

  logic               m4_valid_r;
  cwpc_pkg::out_pix_t m4_pix_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_full[i] = (PW'(m3_t_r[i]) << 8) - PW'(m3_t_r[i]);
      if (m3_mode_r == cwpc_pkg::MODE_HSL) begin
        p_shr[i] = p_full[i] >> (FRAC_BITS + 1);
      end else begin
        p_shr[i] = p_full[i] >> FRAC_BITS;
      end
      ch[i] = (p_shr[i] > PW'(cwpc_pkg::CHAN_MAX)) ? CW'(cwpc_pkg::CHAN_MAX) : p_shr[i][CW-1:0];
    end
  end

  always_comb begin
    case (m3_mode_r) inside
      cwpc_pkg::MODE_RGB, cwpc_pkg::MODE_CMY: begin
        pix_nxt.red   = m3_red_r;
        pix_nxt.green = m3_green_r;
        pix_nxt.blue  = m3_blue_r;
      end
      default: begin
        pix_nxt.red   = ch[0];
        pix_nxt.green = ch[1];
        pix_nxt.blue  = ch[2];
      end
    endcase
  end

  assign en4      = !m4_valid_r || dn_ready;
  assign en3      = !m3_valid_r || en4;
  assign en2      = !m2_valid_r || en3;
  assign en1      = !m1_valid_r || en2;
  assign up_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_valid_r <= 1'b0;
      m2_valid_r <= 1'b0;
      m3_valid_r <= 1'b0;
      m4_valid_r <= 1'b0;
    end else begin
      if (en1) begin
        m1_valid_r <= up_valid;
      end
      if (en2) begin
        m2_valid_r <= m1_valid_r;
      end
      if (en3) begin
        m3_valid_r <= m2_valid_r;
      end
      if (en4) begin
        m4_valid_r <= m3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      m1_ctl_r   <= up_ctl;
      m1_lv_r    <= up_lv;
      m1_f_r     <= up_f;
      m1_c_r     <= c_prod[FRAC_BITS +: LW];
      m1_red_r   <= up_quo[CW-1:0];
      m1_green_r <= g_prod[cwpc_pkg::DIV6_SHIFT +: CW];
      m1_blue_r  <= up_blue;
    end
    if (en2) begin
      m2_ctl_r   <= m1_ctl_r;
      m2_lv_r    <= m1_lv_r;
      m2_c_r     <= m1_c_r;
      m2_x_r     <= x_prod[FRAC_BITS +: LW];
      m2_red_r   <= m1_red_r;
      m2_green_r <= m1_green_r;
      m2_blue_r  <= m1_blue_r;
    end
    if (en3) begin
      m3_mode_r  <= m2_ctl_r.mode;
      m3_t_r[0]  <= t_nxt[0];
      m3_t_r[1]  <= t_nxt[1];
      m3_t_r[2]  <= t_nxt[2];
      m3_red_r   <= m2_red_r;
      m3_green_r <= m2_green_r;
      m3_blue_r  <= m2_blue_r;
    end
    if (en4) begin
      m4_pix_r   <= pix_nxt;
    end
  end

  assign dn_valid = m4_valid_r;
  assign dn_pix   = m4_pix_r;

  `CWPC_ASSERT_IMP(a_chroma_le_one, clk, rst_n, m1_valid_r, m1_c_r <= LW'(1 << FRAC_BITS))
  `CWPC_ASSERT_IMP(a_x_le_chroma, clk, rst_n, m2_valid_r, m2_x_r <= m2_c_r)

endmodule

// File: rtl/core/color_wheel_pixel_converter_top.sv
// Colour wheel pixel converter: turns a hue angle (4096 units per sixth of a
// turn) and a distance from the wheel centre into an 8-bit RGB pixel, in RGB,
// CMY, HSV or HSL wheel mode. It takes one pixel per clock unless the output
// stalls it, and is built from two preparation stages, a restoring divider
// that produces one quotient bit per stage (FRAC_BITS + 1 stages, setting the
// depth), and four stages of multiply, mix and scale. Back-pressure on the
// output stalls only the stages that are full, so bubbles close up. The mode,
// radius and level registers come out of reset as HSV, 256 and 1.0 and must be
// written only while no pixel is in flight.
`include "color_wheel_pixel_converter_top_macros.svh"

module color_wheel_pixel_converter_top #(
  parameter int FRAC_BITS = cwpc_pkg::FRAC_BITS_DEF,
  parameter int DIST_BITS = cwpc_pkg::DIST_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  cwpc_pkg::in_beat_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output cwpc_pkg::out_pix_t                out_data,
  input  logic                              cfg_wr_en,
  input  logic [cwpc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [cwpc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int DW    = (DIST_BITS < cwpc_pkg::DIST_W) ? DIST_BITS : cwpc_pkg::DIST_W;
  localparam int LW    = FRAC_BITS + 1;
  localparam int NW    = DW + FRAC_BITS + 1;
  localparam int TAG_W = $bits(cwpc_pkg::ctl_t) + 3 * LW + cwpc_pkg::GPRE_W
                         + cwpc_pkg::CHAN_W;

  cwpc_pkg::mode_t                 wheel_mode_r;
  logic [cwpc_pkg::RADIUS_W-1:0]   wheel_radius_r;
  logic [cwpc_pkg::LEVEL_W-1:0]    level_r;
  cwpc_pkg::cfg_t                  cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_mode_r   <= cwpc_pkg::MODE_RST;
      wheel_radius_r <= cwpc_pkg::RADIUS_RST;
      level_r        <= cwpc_pkg::LEVEL_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx)
        cwpc_pkg::REG_WHEEL_MODE: begin
          wheel_mode_r <= cwpc_pkg::mode_t'(cfg_wdata[cwpc_pkg::MODE_W-1:0]);
        end
        cwpc_pkg::REG_WHEEL_RADIUS: begin
          wheel_radius_r <= cfg_wdata[cwpc_pkg::RADIUS_W-1:0];
        end
        cwpc_pkg::REG_LEVEL: begin
          level_r <= cfg_wdata[cwpc_pkg::LEVEL_W-1:0];
        end
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

  assign cfg.wheel_mode   = wheel_mode_r;
  assign cfg.wheel_radius = wheel_radius_r;
  assign cfg.level        = level_r;

  // Preparation to divider.
  logic                         p_valid;
  logic                         p_ready;
  logic [NW-1:0]                p_num;
  logic [DW-1:0]                p_rad;
  cwpc_pkg::ctl_t               p_ctl;
  logic [LW-1:0]                p_lv;
  logic [LW-1:0]                p_k;
  logic [LW-1:0]                p_f;
  logic [cwpc_pkg::GPRE_W-1:0]  p_gpre;
  logic [cwpc_pkg::CHAN_W-1:0]  p_blue;
  logic [TAG_W-1:0]             p_tag;

  // Divider to mixer.
  logic                         d_valid;
  logic                         d_ready;
  logic [LW-1:0]                d_quo;
  logic [TAG_W-1:0]             d_tag;
  cwpc_pkg::ctl_t               d_ctl;
  logic [LW-1:0]                d_lv;
  logic [LW-1:0]                d_k;
  logic [LW-1:0]                d_f;
  logic [cwpc_pkg::GPRE_W-1:0]  d_gpre;
  logic [cwpc_pkg::CHAN_W-1:0]  d_blue;

  cwpc_prep #(
    .FRAC_BITS (FRAC_BITS),
    .DIST_BITS (DIST_BITS)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .dn_valid (p_valid),
    .dn_ready (p_ready),
    .dn_num   (p_num),
    .dn_rad   (p_rad),
    .dn_ctl   (p_ctl),
    .dn_lv    (p_lv),
    .dn_k     (p_k),
    .dn_f     (p_f),
    .dn_gpre  (p_gpre),
    .dn_blue  (p_blue)
  );

  // Everything the mixer needs rides alongside the divider as one tag.
  assign p_tag = {p_ctl, p_lv, p_k, p_f, p_gpre, p_blue};

  cwpc_div #(
    .FRAC_BITS (FRAC_BITS),
    .DIST_BITS (DIST_BITS),
    .TAG_W     (TAG_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (p_valid),
    .up_ready (p_ready),
    .up_num   (p_num),
    .up_rad   (p_rad),
    .up_tag   (p_tag),
    .dn_valid (d_valid),
    .dn_ready (d_ready),
    .dn_quo   (d_quo),
    .dn_tag   (d_tag)
  );

  assign {d_ctl, d_lv, d_k, d_f, d_gpre, d_blue} = d_tag;

  cwpc_mix #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (d_valid),
    .up_ready (d_ready),
    .up_quo   (d_quo),
    .up_ctl   (d_ctl),
    .up_lv    (d_lv),
    .up_k     (d_k),
    .up_f     (d_f),
    .up_gpre  (d_gpre),
    .up_blue  (d_blue),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_pix   (out_data)
  );

  // The input can only be held off when the whole pipe, output included, is full.
  `CWPC_ASSERT_IMP(a_stall_needs_output, clk, rst_n, !in_ready, out_valid && !out_ready)

endmodule

// File: tb/sv/color_wheel_pixel_converter_checker.sv
`timescale 1ns / 1ps

module color_wheel_pixel_converter_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  cwpc_pkg::in_beat_t                in_data,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  cwpc_pkg::out_pix_t                out_data,
  input  logic                              cfg_wr_en,
  input  logic [cwpc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [cwpc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output int                                mismatches,
  output int                                pending,
  output int                                pixels_checked
);

  import cwpc_pkg::*;

  localparam int          FRAC = FRAC_BITS_DEF;
  localparam int unsigned ONE  = 1 << FRAC;
  localparam int unsigned TURN = 6 * ONE;
  localparam int          REPORT_LIMIT = 10;

  mode_t               wheel_mode_q;
  logic [RADIUS_W-1:0] wheel_radius_q;
  logic [LEVEL_W-1:0]  level_q;

  out_pix_t pix_expected[$];

  function automatic out_pix_t convert_pixel(input in_beat_t px);
    int unsigned ang, d, rad, lv, s, k, c, f, x, twice, wrapped;
    int unsigned v[3];
    int unsigned ch[3];
    out_pix_t    pix;
    ang = px.hue_angle;
    d   = px.radial_distance;
    rad = wheel_radius_q;
    lv  = level_q;
    if (ang > TURN) ang = TURN;
    if (lv > ONE) lv = ONE;
    if (rad == 0) rad = 1;
    if (d > rad) d = rad;
    case (wheel_mode_q)
      MODE_RGB: begin
        ch[0] = (255 * d) / rad;
        ch[1] = (255 * ang) / TURN;
        ch[2] = (255 * lv) >> FRAC;
      end
      MODE_CMY: begin
        ch[0] = (255 * (rad - d)) / rad;
        ch[1] = (255 * (TURN - ang)) / TURN;
        ch[2] = (255 * (ONE - lv)) >> FRAC;
      end
      default: begin
        s = (d << FRAC) / rad;
        twice = 2 * lv;
        if (wheel_mode_q == MODE_HSV) k = lv;
        else k = ONE - ((twice > ONE) ? twice - ONE : ONE - twice);
        c = (k * s) >> FRAC;
        wrapped = ang % (2 * ONE);
        f = ONE - ((wrapped > ONE) ? wrapped - ONE : ONE - wrapped);
        x = (c * f) >> FRAC;
        // The upper boundary of each sixth belongs to the lower sector.
        if (ang <= ONE) begin
          v[0] = c; v[1] = x; v[2] = 0;
        end else if (ang <= 2 * ONE) begin
          v[0] = x; v[1] = c; v[2] = 0;
        end else if (ang <= 3 * ONE) begin
          v[0] = 0; v[1] = c; v[2] = x;
        end else if (ang <= 4 * ONE) begin
          v[0] = 0; v[1] = x; v[2] = c;
        end else if (ang <= 5 * ONE) begin
          v[0] = x; v[1] = 0; v[2] = c;
        end else begin
          v[0] = c; v[1] = 0; v[2] = x;
        end
        for (int i = 0; i < 3; i++) begin
          if (wheel_mode_q == MODE_HSV) ch[i] = ((v[i] + lv - c) * 255) >> FRAC;
          else ch[i] = ((2 * v[i] + 2 * lv - c) * 255) >> (FRAC + 1);
        end
      end
    endcase
    for (int i = 0; i < 3; i++)
      if (ch[i] > CHAN_MAX) ch[i] = CHAN_MAX;
    pix.red   = ch[0][CHAN_W-1:0];
    pix.green = ch[1][CHAN_W-1:0];
    pix.blue  = ch[2][CHAN_W-1:0];
    return pix;
  endfunction

  initial begin
    mismatches     = 0;
    pending        = 0;
    pixels_checked = 0;
  end

  always @(posedge clk) begin
    out_pix_t want;
    if (!rst_n) begin
      wheel_mode_q   <= MODE_RST;
      wheel_radius_q <= RADIUS_RST;
      level_q        <= LEVEL_RST;
      pix_expected.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pix_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $realtime,
                     out_data.red, out_data.green, out_data.blue);
        end else begin
          want = pix_expected.pop_front();
          pixels_checked++;
          if (out_data.red !== want.red || out_data.green !== want.green ||
              out_data.blue !== want.blue) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: pixel %0d expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       $realtime, pixels_checked, want.red, want.green, want.blue,
                       out_data.red, out_data.green, out_data.blue);
          end
        end
      end
      if (in_valid && in_ready)
        pix_expected.push_back(convert_pixel(in_data));
      // Writes to the unmapped index fall through and are ignored.
      if (cfg_wr_en) begin
        case (cfg_idx)
          REG_WHEEL_MODE:   wheel_mode_q   <= mode_t'(cfg_wdata[MODE_W-1:0]);
          REG_WHEEL_RADIUS: wheel_radius_q <= cfg_wdata[RADIUS_W-1:0];
          REG_LEVEL:        level_q        <= cfg_wdata[LEVEL_W-1:0];
          default: ;
        endcase
      end
    end
    pending = pix_expected.size();
  end

endmodule

// File: tb/sv/color_wheel_pixel_converter_top_tb.sv
`timescale 1ns / 1ps

module color_wheel_pixel_converter_top_tb;

  import cwpc_pkg::*;

  localparam int LATENCY     = FRAC_BITS_DEF + 7;
  localparam int DRAIN       = LATENCY + 8;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT       = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_beat_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_pix_t              out_data;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int mismatches;
  int pending;
  int pixels_checked;
  int pixels_sent  = 0;
  int idle_pct     = 0;
  int stall_pct    = 0;
  int holds_wanted = 0;
  int cycles       = 0;
  int cur_radius   = RADIUS_RST;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  color_wheel_pixel_converter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  color_wheel_pixel_converter_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatches),
    .pending        (pending),
    .pixels_checked (pixels_checked)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Output side: random stalls, or a long hold-off whenever one is requested.
  initial begin : receiver
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (holds_done < holds_wanted) begin
        holds_done++;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99, 0) >= stall_pct);
      end
    end
  end

  // Entered and left at a falling edge; valid stays high into the next beat.
  task automatic send_pixel(input int unsigned hue, input int unsigned distance);
    while ($urandom_range(99, 0) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {HUE_W'(hue), DIST_W'(distance)};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_pixel();
    int unsigned hue;
    int unsigned distance;
    int pick;
    pick = $urandom_range(9, 0);
    if (pick < 7) hue = $urandom_range(6 * 4096, 0);
    else if (pick < 8) hue = $urandom_range(6, 0) * 4096 + $urandom_range(2, 0) - 1;
    else hue = $urandom_range(32767, 0);
    pick = $urandom_range(3, 0);
    if (pick < 2) distance = $urandom_range(cur_radius, 0);
    else if (pick == 2) distance = $urandom_range(1023, 0);
    else distance = $urandom_range(1, 0) ? cur_radius : 0;
    send_pixel(hue, distance);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    cfg_wr_en <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_DATA_W'(data);
    @(negedge clk);
  endtask

  // Stops sending, lets the pipeline drain completely, then rewrites every
  // register, the unmapped index included.
  task automatic configure(input int unsigned mode_word, input int unsigned radius_word,
                           input int unsigned level_word);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    write_reg(REG_UNMAPPED, $urandom_range(8191, 0));
    write_reg(REG_WHEEL_MODE, mode_word);
    write_reg(REG_WHEEL_RADIUS, radius_word);
    write_reg(REG_LEVEL, level_word);
    cfg_wr_en  <= 1'b0;
    cur_radius = radius_word & 10'h3FF;
  endtask

  initial begin : stimulus
    int count;
    int unsigned mode_sel, radius, lvl;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_wr_en = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings (HSV, radius 256, full level): sector edges and both
    // ends of the angle, including angles past a full turn.
    send_pixel(0, 0);
    send_pixel(0, 256);
    send_pixel(4096, 256);
    send_pixel(4097, 256);
    send_pixel(8192, 255);
    send_pixel(12288, 128);
    send_pixel(16384, 1023);
    send_pixel(20480, 200);
    send_pixel(20481, 256);
    send_pixel(24576, 256);
    send_pixel(32767, 100);

    configure(MODE_RGB, 1023, 0);
    send_pixel(0, 1023);
    send_pixel(24576, 0);
    send_pixel(12000, 512);

    configure(MODE_CMY, 1, 4096);
    send_pixel(0, 0);
    send_pixel(24576, 1);
    send_pixel(32767, 1023);

    // Zero radius acts as one; a level above one saturates.
    configure(MODE_HSL, 0, 8191);
    send_pixel(6000, 0);
    send_pixel(6000, 1);

    configure(MODE_HSL, 300, 2048);
    send_pixel(2048, 300);
    send_pixel(10240, 150);
    send_pixel(22528, 299);

    for (int ph = 0; ph < 6; ph++) begin
      radius = $urandom_range(1023, 1);
      lvl    = $urandom_range(4096, 0);
      case (ph)
        0: begin mode_sel = MODE_RGB; idle_pct = 0;  stall_pct = 0;  count = 80; end
        1: begin
          mode_sel = MODE_CMY; idle_pct = 78; stall_pct = 0; count = 60;
          radius = 1023; lvl = 0;
        end
        2: begin
          mode_sel = MODE_HSV; idle_pct = 0; stall_pct = 78; count = 60;
          lvl = $urandom_range(8191, 0);
        end
        3: begin mode_sel = MODE_HSL; idle_pct = 28; stall_pct = 28; count = 80; end
        4: begin
          mode_sel = MODE_HSV; idle_pct = 0; stall_pct = 0; count = 100;
          radius = 256; lvl = 4096;
        end
        default: begin
          mode_sel = MODE_HSL; idle_pct = 28; stall_pct = 28; count = 40;
          radius = 1; lvl = 2048;
        end
      endcase
      // Unused upper bits of the data word carry noise.
      configure(mode_sel | ($urandom_range(2047, 0) << MODE_W),
                radius | ($urandom_range(7, 0) << RADIUS_W), lvl);
      // With the output held off, the sender keeps offering beats until the
      // pipeline fills and the input stalls.
      if (ph == 4) holds_wanted++;
      repeat (count) send_random_pixel();
    end

    in_valid  <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);

    $display("Sent %0d pixels and checked %0d results in RGB, CMY, HSV and HSL modes,",
             pixels_sent, pixels_checked);
    $display("with radius and level extremes, gaps, stalls and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
